[rtl/mtc_pkg.sv]
package mtc_pkg;

    localparam int NUM_LINES  = 32;
    localparam int NUM_BLOCKS = 1024;
    localparam int ADDR_W     = $clog2(NUM_BLOCKS);
    localparam int IDX_W      = $clog2(NUM_LINES);
    localparam int TAG_W      = ADDR_W - IDX_W;

    typedef enum logic [1:0] {
        MESI_I = 2'd0,
        MESI_S = 2'd1,
        MESI_E = 2'd2,
        MESI_M = 2'd3
    } t_mesi;

    typedef enum logic [1:0] {
        BUS_NONE  = 2'd0,
        BUS_READ  = 2'd1,
        BUS_INV   = 2'd2,
        BUS_RWITM = 2'd3
    } t_bus_op;

    typedef enum logic {
        FSM_IDLE   = 1'b0,
        FSM_LOOKUP = 1'b1
    } t_fsm_state;

    typedef struct packed {
        logic load;
        logic update;
    } t_dp_cmd;

endpackage

[rtl/mtc_ctrl.sv]
module mtc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output mtc_pkg::t_dp_cmd o_cmd
);

    mtc_pkg::t_fsm_state r_state;
    mtc_pkg::t_fsm_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtc_pkg::FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mtc_pkg::FSM_IDLE: begin
                if (start) begin
                    n_state = mtc_pkg::FSM_LOOKUP;
                end
            end
            mtc_pkg::FSM_LOOKUP: begin
                n_state = mtc_pkg::FSM_IDLE;
            end
            default: begin
                n_state = mtc_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        busy         = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.update = 1'b0;
        case (r_state)
            mtc_pkg::FSM_IDLE: begin
                o_cmd.load = start;
            end
            mtc_pkg::FSM_LOOKUP: begin
                busy         = 1'b1;
                o_cmd.update = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

[rtl/mtc_datapath.sv]
module mtc_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mtc_pkg::t_dp_cmd           i_cmd,
    input  logic                       i_req_type,
    input  logic                       i_cpu_id,
    input  logic [mtc_pkg::ADDR_W-1:0] i_block_addr,
    output logic                       o_valid,
    output logic                       o_hit,
    output logic [1:0]                 o_bus_op,
    output logic                       o_peer_writeback,
    output logic [1:0]                 o_own_new_state,
    output logic [1:0]                 o_peer_old_state,
    output logic [1:0]                 o_peer_new_state,
    output logic                       o_victim_dirty
);

    logic [mtc_pkg::TAG_W-1:0] r_tag_mem0 [mtc_pkg::NUM_LINES];
    logic [mtc_pkg::TAG_W-1:0] r_tag_mem1 [mtc_pkg::NUM_LINES];
    mtc_pkg::t_mesi            r_line_state [2][mtc_pkg::NUM_LINES];

    logic                      r_is_write;
    logic                      r_cpu;
    logic [mtc_pkg::IDX_W-1:0] r_idx;
    logic [mtc_pkg::TAG_W-1:0] r_tag;
    logic [mtc_pkg::TAG_W-1:0] r_rd0;
    logic [mtc_pkg::TAG_W-1:0] r_rd1;
    mtc_pkg::t_mesi            r_own_old;
    mtc_pkg::t_mesi            r_peer_st;

    logic [mtc_pkg::IDX_W-1:0] in_idx;
    logic [mtc_pkg::TAG_W-1:0] in_tag;
    logic [mtc_pkg::TAG_W-1:0] own_tag;
    logic [mtc_pkg::TAG_W-1:0] peer_tag;
    logic                      hit;
    logic                      peer_has;
    mtc_pkg::t_mesi            peer_old;
    mtc_pkg::t_mesi            peer_new;
    mtc_pkg::t_mesi            own_new;
    mtc_pkg::t_bus_op          bus;
    logic                      wb;
    logic                      victim;

    assign in_idx = i_block_addr[mtc_pkg::IDX_W-1:0];
    assign in_tag = i_block_addr[mtc_pkg::ADDR_W-1:mtc_pkg::IDX_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_write <= i_req_type;
            r_cpu      <= i_cpu_id;
            r_idx      <= in_idx;
            r_tag      <= in_tag;
            r_rd0      <= r_tag_mem0[in_idx];
            r_rd1      <= r_tag_mem1[in_idx];
            r_own_old  <= r_line_state[i_cpu_id][in_idx];
            r_peer_st  <= r_line_state[~i_cpu_id][in_idx];
        end
        if (i_cmd.update && !hit) begin
            if (r_cpu) begin
                r_tag_mem1[r_idx] <= r_tag;
            end else begin
                r_tag_mem0[r_idx] <= r_tag;
            end
        end
    end

    always_comb begin
        own_tag  = r_cpu ? r_rd1 : r_rd0;
        peer_tag = r_cpu ? r_rd0 : r_rd1;
        hit      = (r_own_old != mtc_pkg::MESI_I) && (own_tag == r_tag);
        peer_has = (r_peer_st != mtc_pkg::MESI_I) && (peer_tag == r_tag);
        peer_old = peer_has ? r_peer_st : mtc_pkg::MESI_I;
        peer_new = peer_old;
        own_new  = r_own_old;
        bus      = mtc_pkg::BUS_NONE;
        wb       = 1'b0;
        victim   = 1'b0;
        if (!hit) begin
            victim = (r_own_old == mtc_pkg::MESI_M);
            wb     = (peer_old == mtc_pkg::MESI_M);
            if (!r_is_write) begin
                bus = mtc_pkg::BUS_READ;
                if (peer_has) begin
                    peer_new = mtc_pkg::MESI_S;
                    own_new  = mtc_pkg::MESI_S;
                end else begin
                    own_new = mtc_pkg::MESI_E;
                end
            end else begin
                bus = mtc_pkg::BUS_RWITM;
                if (peer_has) begin
                    peer_new = mtc_pkg::MESI_I;
                end
                own_new = mtc_pkg::MESI_M;
            end
        end else if (r_is_write) begin
            if (r_own_old == mtc_pkg::MESI_S) begin
                bus = mtc_pkg::BUS_INV;
                if (peer_has) begin
                    peer_new = mtc_pkg::MESI_I;
                end
            end
            own_new = mtc_pkg::MESI_M;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                for (int l = 0; l < mtc_pkg::NUM_LINES; l++) begin
                    r_line_state[c][l] <= mtc_pkg::MESI_I;
                end
            end
        end else if (i_cmd.update) begin
            r_line_state[r_cpu][r_idx] <= own_new;
            if (peer_has) begin
                r_line_state[~r_cpu][r_idx] <= peer_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_hit            <= hit;
            o_bus_op         <= bus;
            o_peer_writeback <= wb;
            o_own_new_state  <= own_new;
            o_peer_old_state <= peer_old;
            o_peer_new_state <= peer_new;
            o_victim_dirty   <= victim;
        end
    end

endmodule

[rtl/mesi_two_cache_snoop_controller.sv]
// Snooping MESI controller for two direct-mapped caches of tags and line states. A request
// word is taken at a clock edge where start is high and busy is low. Each request first
// reads both caches' tag memories and line states at the line index into registers, then
// decides the MESI outcome and writes the new tag (on a miss) and states back. The result
// word appears on the result ports in the cycle after that, for exactly one cycle with
// o_valid high, and the receiver cannot stall it; a new request is accepted in that
// same cycle. Line states are Invalid after reset.
module mesi_two_cache_snoop_controller (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_req_type,
    input  logic                       i_cpu_id,
    input  logic [mtc_pkg::ADDR_W-1:0] i_block_addr,
    output logic                       o_valid,
    output logic                       o_hit,
    output logic [1:0]                 o_bus_op,
    output logic                       o_peer_writeback,
    output logic [1:0]                 o_own_new_state,
    output logic [1:0]                 o_peer_old_state,
    output logic [1:0]                 o_peer_new_state,
    output logic                       o_victim_dirty
);

    mtc_pkg::t_dp_cmd cmd;

    mtc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    mtc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_req_type       (i_req_type),
        .i_cpu_id         (i_cpu_id),
        .i_block_addr     (i_block_addr),
        .o_valid          (o_valid),
        .o_hit            (o_hit),
        .o_bus_op         (o_bus_op),
        .o_peer_writeback (o_peer_writeback),
        .o_own_new_state  (o_own_new_state),
        .o_peer_old_state (o_peer_old_state),
        .o_peer_new_state (o_peer_new_state),
        .o_victim_dirty   (o_victim_dirty)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a finished lookup");

    a_inv_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bus_op == mtc_pkg::BUS_INV) |->
        (o_hit && o_own_new_state == mtc_pkg::MESI_M))
        else $error("invalidate issued without a write hit ending in M");

    a_miss_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |->
        (o_bus_op == mtc_pkg::BUS_READ || o_bus_op == mtc_pkg::BUS_RWITM))
        else $error("miss completed without a bus read");

    a_wb_peer_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_peer_writeback) |->
        (o_peer_old_state == mtc_pkg::MESI_M && !o_hit))
        else $error("write-back reported without a modified peer on a miss");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic             hit;
        mtc_pkg::t_bus_op bus_op;
        logic             peer_writeback;
        mtc_pkg::t_mesi   own_new_state;
        mtc_pkg::t_mesi   peer_old_state;
        mtc_pkg::t_mesi   peer_new_state;
        logic             victim_dirty;
    } t_snoop_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic                       i_req_type;
    logic                       i_cpu_id;
    logic [mtc_pkg::ADDR_W-1:0] i_block_addr;
    logic                       o_valid;
    logic                       o_hit;
    logic [1:0]                 o_bus_op;
    logic                       o_peer_writeback;
    logic [1:0]                 o_own_new_state;
    logic [1:0]                 o_peer_old_state;
    logic [1:0]                 o_peer_new_state;
    logic                       o_victim_dirty;

    mtc_pkg::t_mesi            line_state_q [2*mtc_pkg::NUM_LINES];
    logic [mtc_pkg::TAG_W-1:0] line_tag_q   [2*mtc_pkg::NUM_LINES];
    t_snoop_result             expected_results [$];
    int                        mismatch_count;
    int                        cycle_count;
    int                        idle_pct;
    logic [mtc_pkg::IDX_W-1:0] hot_index [4];
    logic [mtc_pkg::TAG_W-1:0] hot_tag   [3];

    mesi_two_cache_snoop_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_cpu_id         (i_cpu_id),
        .i_block_addr     (i_block_addr),
        .o_valid          (o_valid),
        .o_hit            (o_hit),
        .o_bus_op         (o_bus_op),
        .o_peer_writeback (o_peer_writeback),
        .o_own_new_state  (o_own_new_state),
        .o_peer_old_state (o_peer_old_state),
        .o_peer_new_state (o_peer_new_state),
        .o_victim_dirty   (o_victim_dirty)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_snoop_result predict_access(input logic is_write, input logic cpu,
                                                     input logic [mtc_pkg::ADDR_W-1:0] addr);
        t_snoop_result             res;
        int                        line_idx;
        logic [mtc_pkg::TAG_W-1:0] line_tag;
        int                        own;
        int                        peer;
        mtc_pkg::t_mesi            own_old;
        logic                      peer_has;

        line_idx = int'(addr) % mtc_pkg::NUM_LINES;
        line_tag = mtc_pkg::TAG_W'(int'(addr) / mtc_pkg::NUM_LINES);
        own      = cpu ? mtc_pkg::NUM_LINES + line_idx : line_idx;
        peer     = cpu ? line_idx : mtc_pkg::NUM_LINES + line_idx;
        own_old  = line_state_q[own];
        peer_has = (line_state_q[peer] != mtc_pkg::MESI_I) && (line_tag_q[peer] == line_tag);

        res.hit            = (own_old != mtc_pkg::MESI_I) && (line_tag_q[own] == line_tag);
        res.bus_op         = mtc_pkg::BUS_NONE;
        res.peer_writeback = 1'b0;
        res.own_new_state  = own_old;
        res.peer_old_state = peer_has ? line_state_q[peer] : mtc_pkg::MESI_I;
        res.peer_new_state = res.peer_old_state;
        res.victim_dirty   = 1'b0;

        if (!res.hit) begin
            res.victim_dirty   = (own_old == mtc_pkg::MESI_M);
            res.peer_writeback = (res.peer_old_state == mtc_pkg::MESI_M);
            line_tag_q[own]    = line_tag;
            if (!is_write) begin
                res.bus_op = mtc_pkg::BUS_READ;
                if (peer_has) begin
                    res.peer_new_state = mtc_pkg::MESI_S;
                    res.own_new_state  = mtc_pkg::MESI_S;
                end else begin
                    res.own_new_state = mtc_pkg::MESI_E;
                end
            end else begin
                res.bus_op = mtc_pkg::BUS_RWITM;
                if (peer_has) begin
                    res.peer_new_state = mtc_pkg::MESI_I;
                end
                res.own_new_state = mtc_pkg::MESI_M;
            end
        end else if (is_write) begin
            if (own_old == mtc_pkg::MESI_S) begin
                res.bus_op = mtc_pkg::BUS_INV;
                if (peer_has) begin
                    res.peer_new_state = mtc_pkg::MESI_I;
                end
            end
            res.own_new_state = mtc_pkg::MESI_M;
        end

        line_state_q[own] = res.own_new_state;
        if (peer_has) begin
            line_state_q[peer] = res.peer_new_state;
        end
        return res;
    endfunction

    function automatic void report_mismatch(input string what, input t_snoop_result exp_res,
                                            input t_snoop_result act_res);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected hit=%0d bus=%0d wb=%0d own=%0d pold=%0d pnew=%0d vd=%0d",
                     $realtime, what, exp_res.hit, exp_res.bus_op, exp_res.peer_writeback,
                     exp_res.own_new_state, exp_res.peer_old_state, exp_res.peer_new_state,
                     exp_res.victim_dirty);
            $display("%0t: %s: actual   hit=%0d bus=%0d wb=%0d own=%0d pold=%0d pnew=%0d vd=%0d",
                     $realtime, what, act_res.hit, act_res.bus_op, act_res.peer_writeback,
                     act_res.own_new_state, act_res.peer_old_state, act_res.peer_new_state,
                     act_res.victim_dirty);
        end
    endfunction

    always @(posedge i_clk) begin : result_checker
        t_snoop_result act_res;
        t_snoop_result exp_res;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            act_res.hit            = o_hit;
            act_res.bus_op         = mtc_pkg::t_bus_op'(o_bus_op);
            act_res.peer_writeback = o_peer_writeback;
            act_res.own_new_state  = mtc_pkg::t_mesi'(o_own_new_state);
            act_res.peer_old_state = mtc_pkg::t_mesi'(o_peer_old_state);
            act_res.peer_new_state = mtc_pkg::t_mesi'(o_peer_new_state);
            act_res.victim_dirty   = o_victim_dirty;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", '0, act_res);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_valid !== 1'b1
                    || act_res.hit !== exp_res.hit
                    || act_res.bus_op !== exp_res.bus_op
                    || act_res.peer_writeback !== exp_res.peer_writeback
                    || act_res.own_new_state !== exp_res.own_new_state
                    || act_res.peer_old_state !== exp_res.peer_old_state
                    || act_res.peer_new_state !== exp_res.peer_new_state
                    || act_res.victim_dirty !== exp_res.victim_dirty) begin
                    report_mismatch("field mismatch", exp_res, act_res);
                end
            end
        end
    end

    task automatic send_request(input logic is_write, input logic cpu,
                                input logic [mtc_pkg::ADDR_W-1:0] addr);
        i_req_type   <= is_write;
        i_cpu_id     <= cpu;
        i_block_addr <= addr;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(negedge i_clk);
            @(posedge i_clk);
        end
        expected_results.push_back(predict_access(is_write, cpu, addr));
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic test_coherence_transitions();
        send_request(1'b0, 1'b0, 10'd0);
        send_request(1'b0, 1'b1, 10'd0);
        send_request(1'b1, 1'b0, 10'd0);
        send_request(1'b0, 1'b1, 10'd0);
        send_request(1'b1, 1'b1, 10'd0);
        send_request(1'b1, 1'b0, 10'd1023);
        send_request(1'b0, 1'b0, 10'd991);
        send_request(1'b1, 1'b0, 10'd991);
        send_request(1'b1, 1'b1, 10'd991);
        send_request(1'b0, 1'b0, 10'd991);
        send_request(1'b0, 1'b0, 10'd991);
        send_request(1'b1, 1'b1, 10'd991);
        send_request(1'b1, 1'b0, 10'd0);
        send_request(1'b0, 1'b1, 10'd32);
    endtask

    task automatic test_address_extremes();
        send_request(1'b1, 1'b1, 10'd1023);
        send_request(1'b0, 1'b0, 10'd1023);
        send_request(1'b0, 1'b1, 10'h155);
        send_request(1'b1, 1'b0, 10'h2AA);
        send_request(1'b1, 1'b1, 10'h155);
        send_request(1'b0, 1'b0, 10'h2AA);
    endtask

    // Most requests go to a few lines and tags so that sharing, upgrades and
    // evictions of dirty lines happen often; the rest spread over all blocks.
    task automatic test_random_traffic(input int count, input int sender_idle_pct);
        logic [mtc_pkg::ADDR_W-1:0] addr;
        idle_pct = sender_idle_pct;
        foreach (hot_index[k]) hot_index[k] = mtc_pkg::IDX_W'($urandom);
        foreach (hot_tag[k]) hot_tag[k] = mtc_pkg::TAG_W'($urandom);
        repeat (count) begin
            if ($urandom_range(99) < 75) begin
                addr = {hot_tag[$urandom_range(2)], hot_index[$urandom_range(3)]};
            end else begin
                addr = mtc_pkg::ADDR_W'($urandom);
            end
            send_request(1'($urandom), 1'($urandom), addr);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_req_type     = 1'b0;
        i_cpu_id       = 1'b0;
        i_block_addr   = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        idle_pct       = 24;
        foreach (line_state_q[k]) begin
            line_state_q[k] = mtc_pkg::MESI_I;
            line_tag_q[k]   = '0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_coherence_transitions();
        test_address_extremes();
        test_random_traffic(340, 24);
        test_random_traffic(330, 73);
        test_random_traffic(340, 0);

        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[mesi_two_cache_snoop_controller.f]
rtl/mtc_pkg.sv
rtl/mtc_ctrl.sv
rtl/mtc_datapath.sv
rtl/mesi_two_cache_snoop_controller.sv
tb/tb.sv
